@@ rtl/cobb_pkg.sv @@
// Shared widths, constants, context record and search schedule for the capsule/box test.
`default_nettype none

package cobb_pkg;

    localparam int COORD_BITS   = 20;
    localparam int QBITS        = 15;
    localparam int QFRAC        = 13;
    localparam int TFRAC        = 32;
    localparam int SEARCH_STEPS = 24;
    localparam int NPAIR        = SEARCH_STEPS + 2;

    localparam int HX_W   = COORD_BITS;
    localparam int DF_W   = COORD_BITS + 1;
    localparam int V_W    = COORD_BITS + 3;
    localparam int U_W    = QBITS + 1;
    localparam int PV_W   = U_W + V_W;
    localparam int C_W    = PV_W + 1;
    localparam int PT_W   = U_W + C_W;
    localparam int ACC_W  = PT_W + 1;
    localparam int QSH    = 2 * QFRAC;
    localparam int LS_W   = COORD_BITS + 10;
    localparam int SD_W   = LS_W + 1;
    localparam int T_W    = TFRAC + 1;
    localparam int TL_W   = 17;
    localparam int TH_W   = T_W - TL_W;
    localparam int PH_W   = SD_W + TH_W + 1;
    localparam int PL_W   = SD_W + TL_W + 1;
    localparam int PR_W   = SD_W + T_W + 1;
    localparam int D_W    = LS_W - 1;
    localparam int SQ_W   = 2 * D_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ER2_W  = 2 * HX_W + 2;
    localparam int DIST_W = 42;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [SUM_W-1:0]  MARGIN   = SUM_W'(3);

    // cross product operand indexes: r[i] = a[AX1[i]]*b[AX2[i]] - a[AX2[i]]*b[AX1[i]]
    localparam int AX1 [3] = '{1, 2, 0};
    localparam int AX2 [3] = '{2, 0, 1};

    typedef struct packed {
        logic [2:0][LS_W-1:0] seg_a;
        logic [2:0][SD_W-1:0] seg_d;
        logic [2:0][HX_W-1:0] hext;
        logic [T_W-1:0]       lo;
        logic [ER2_W-1:0]     er2;
        logic [SUM_W-1:0]     best;
    } ctx_t;

    // width of the search interval before step n (same on either branch)
    function automatic logic [T_W-1:0] span_at(input int n);
        logic [T_W-1:0] r;
        r = T_W'(1) << TFRAC;
        for (int k = 0; k < n; k++)
        begin
            r = r - r / 3;
        end
        return r;
    endfunction

    function automatic logic [T_W-1:0] third_at(input int n);
        return span_at(n) / 3;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cobb_pair.sv @@
// Five-stage pipelined sampler: squared segment-to-box distance at two parameters.
`default_nettype none

module cobb_pair (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire cobb_pkg::ctx_t              ctx_in,
    input  wire logic [cobb_pkg::T_W-1:0]    ta,
    input  wire logic [cobb_pkg::T_W-1:0]    tb,
    output logic                             out_vld,
    output cobb_pkg::ctx_t                   ctx_out,
    output logic [cobb_pkg::SUM_W-1:0]       sum_a,
    output logic [cobb_pkg::SUM_W-1:0]       sum_b
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    cobb_pkg::ctx_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;

    logic signed [cobb_pkg::PH_W-1:0] ph_next [2][3];
    logic signed [cobb_pkg::PH_W-1:0] ph_reg  [2][3];
    logic signed [cobb_pkg::PL_W-1:0] pl_next [2][3];
    logic signed [cobb_pkg::PL_W-1:0] pl_reg  [2][3];
    logic [cobb_pkg::LS_W-1:0]        p_next  [2][3];
    logic [cobb_pkg::LS_W-1:0]        p_reg   [2][3];
    logic [cobb_pkg::D_W-1:0]         d_next  [2][3];
    logic [cobb_pkg::D_W-1:0]         d_reg   [2][3];
    logic [cobb_pkg::SQ_W-1:0]        sq_next [2][3];
    logic [cobb_pkg::SQ_W-1:0]        sq_reg  [2][3];
    logic [cobb_pkg::SUM_W-1:0]       sum_next [2];
    logic [cobb_pkg::SUM_W-1:0]       sum_reg  [2];

    always_comb
    begin
        logic [cobb_pkg::T_W-1:0] t;
        for (int s = 0; s < 2; s++)
        begin
            t = (s == 0) ? ta : tb;
            for (int i = 0; i < 3; i++)
            begin
                ph_next[s][i] = $signed(ctx_in.seg_d[i])
                              * $signed({1'b0, t[cobb_pkg::T_W-1:cobb_pkg::TL_W]});
                pl_next[s][i] = $signed(ctx_in.seg_d[i])
                              * $signed({1'b0, t[cobb_pkg::TL_W-1:0]});
            end
        end
    end

    always_comb
    begin
        logic signed [cobb_pkg::PR_W-1:0] full;
        logic signed [cobb_pkg::PR_W-1:0] shifted;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                full = (cobb_pkg::PR_W'(ph_reg[s][i]) <<< cobb_pkg::TL_W)
                     + cobb_pkg::PR_W'(pl_reg[s][i])
                     + (cobb_pkg::PR_W'(1) <<< (cobb_pkg::TFRAC - 1));
                shifted = full >>> cobb_pkg::TFRAC;
                p_next[s][i] = c1_reg.seg_a[i] + shifted[cobb_pkg::LS_W-1:0];
            end
        end
    end

    always_comb
    begin
        logic [cobb_pkg::LS_W-1:0]      m;
        logic signed [cobb_pkg::LS_W:0] diff;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m = p_reg[s][i][cobb_pkg::LS_W-1] ? (~p_reg[s][i] + 1'b1) : p_reg[s][i];
                diff = $signed({1'b0, m})
                     - $signed({(cobb_pkg::LS_W + 1 - cobb_pkg::HX_W)'(0), c2_reg.hext[i]});
                d_next[s][i] = (diff > 0) ? diff[cobb_pkg::D_W-1:0] : '0;
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_next[s][i] = d_reg[s][i] * d_reg[s][i];
            end
            sum_next[s] = cobb_pkg::SUM_W'(sq_reg[s][0]) + cobb_pkg::SUM_W'(sq_reg[s][1])
                        + cobb_pkg::SUM_W'(sq_reg[s][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= ctx_in;
            c2_reg   <= c1_reg;
            c3_reg   <= c2_reg;
            c4_reg   <= c3_reg;
            c5_reg   <= c4_reg;
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            p_reg    <= p_next;
            d_reg    <= d_next;
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
        end
    end

    assign out_vld = v5_reg;
    assign ctx_out = c5_reg;
    assign sum_a   = sum_reg[0];
    assign sum_b   = sum_reg[1];

endmodule

`default_nettype wire

@@ rtl/capsule_obb_overlap_test_top.sv @@
// Capsule versus oriented box overlap test: rotation front end, ternary search pipeline, output.
// Throughput: one beat per cycle; the whole pipeline holds only while a result waits unread.
// Every search step is its own sampler plus a compare stage (24 steps, 26 samplers in all).
// Reset clears all valid bits and the output register; payload registers are not reset.
`default_nettype none

module capsule_obb_overlap_test_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   req_valid,
    output logic                                        req_ready,
    input  wire logic [3*cobb_pkg::COORD_BITS-1:0]      capsule_center,
    input  wire logic [cobb_pkg::COORD_BITS-1:0]        capsule_radius,
    input  wire logic [cobb_pkg::COORD_BITS-1:0]        capsule_height,
    input  wire logic [cobb_pkg::COORD_BITS-1:0]        skin_width,
    input  wire logic [3*cobb_pkg::COORD_BITS-1:0]      box_center,
    input  wire logic [4*cobb_pkg::QBITS-1:0]           box_rotation,
    input  wire logic [3*cobb_pkg::COORD_BITS-1:0]      box_size,
    output logic                                        rsp_valid,
    input  wire logic                                   rsp_ready,
    output logic                                        overlaps,
    output logic [cobb_pkg::DIST_W-1:0]                 min_squared_distance
);

    localparam int S = cobb_pkg::SEARCH_STEPS;
    localparam int N = cobb_pkg::NPAIR;

    logic en;
    logic r1_vld_reg, r2_vld_reg, r3_vld_reg, r4_vld_reg, r5_vld_reg, r6_vld_reg, r7_vld_reg;
    logic fin_vld_reg, rsp_valid_reg;

    // stage 1: field decode
    logic signed [cobb_pkg::DF_W-1:0]   r1_diff_next [3];
    logic signed [cobb_pkg::DF_W-1:0]   r1_diff_reg  [3];
    logic signed [cobb_pkg::U_W-1:0]    r1_u_next [3];
    logic signed [cobb_pkg::U_W-1:0]    r1_u_reg  [3];
    logic signed [cobb_pkg::QBITS-1:0]  r1_w_next, r1_w_reg;
    logic [cobb_pkg::HX_W-1:0]          r1_hext_next [3];
    logic [cobb_pkg::HX_W-1:0]          r1_hext_reg  [3];
    logic [cobb_pkg::HX_W-1:0]          r1_seg2_next, r1_seg2_reg;
    logic [cobb_pkg::HX_W-1:0]          r1_er_next, r1_er_reg;

    // stage 2: segment ends relative to box, effective radius squared
    logic signed [cobb_pkg::V_W-1:0]    r2_v_next [2][3];
    logic signed [cobb_pkg::V_W-1:0]    r2_v_reg  [2][3];
    logic [cobb_pkg::ER2_W-1:0]         r2_er2_next, r2_er2_reg;
    logic signed [cobb_pkg::U_W-1:0]    r2_u_reg [3];
    logic signed [cobb_pkg::QBITS-1:0]  r2_w_reg;
    logic [cobb_pkg::HX_W-1:0]          r2_hext_reg [3];

    // stage 3: u x v products
    logic signed [cobb_pkg::PV_W-1:0]   r3_pp_next [2][3];
    logic signed [cobb_pkg::PV_W-1:0]   r3_pp_reg  [2][3];
    logic signed [cobb_pkg::PV_W-1:0]   r3_pn_next [2][3];
    logic signed [cobb_pkg::PV_W-1:0]   r3_pn_reg  [2][3];
    logic signed [cobb_pkg::V_W-1:0]    r3_v_reg [2][3];
    logic [cobb_pkg::ER2_W-1:0]         r3_er2_reg;
    logic signed [cobb_pkg::U_W-1:0]    r3_u_reg [3];
    logic signed [cobb_pkg::QBITS-1:0]  r3_w_reg;
    logic [cobb_pkg::HX_W-1:0]          r3_hext_reg [3];

    // stage 4: t = 2 u x v
    logic signed [cobb_pkg::C_W-1:0]    r4_t_next [2][3];
    logic signed [cobb_pkg::C_W-1:0]    r4_t_reg  [2][3];
    logic signed [cobb_pkg::V_W-1:0]    r4_v_reg [2][3];
    logic [cobb_pkg::ER2_W-1:0]         r4_er2_reg;
    logic signed [cobb_pkg::U_W-1:0]    r4_u_reg [3];
    logic signed [cobb_pkg::QBITS-1:0]  r4_w_reg;
    logic [cobb_pkg::HX_W-1:0]          r4_hext_reg [3];

    // stage 5: u x t and w t products
    logic signed [cobb_pkg::PT_W-1:0]   r5_cp_next [2][3];
    logic signed [cobb_pkg::PT_W-1:0]   r5_cp_reg  [2][3];
    logic signed [cobb_pkg::PT_W-1:0]   r5_cn_next [2][3];
    logic signed [cobb_pkg::PT_W-1:0]   r5_cn_reg  [2][3];
    logic signed [cobb_pkg::PT_W-1:0]   r5_wt_next [2][3];
    logic signed [cobb_pkg::PT_W-1:0]   r5_wt_reg  [2][3];
    logic signed [cobb_pkg::V_W-1:0]    r5_v_reg [2][3];
    logic [cobb_pkg::ER2_W-1:0]         r5_er2_reg;
    logic [cobb_pkg::HX_W-1:0]          r5_hext_reg [3];

    // stage 6: rounded box-space ends
    logic signed [cobb_pkg::LS_W-1:0]   r6_l_next [2][3];
    logic signed [cobb_pkg::LS_W-1:0]   r6_l_reg  [2][3];
    logic [cobb_pkg::ER2_W-1:0]         r6_er2_reg;
    logic [cobb_pkg::HX_W-1:0]          r6_hext_reg [3];

    // stage 7: search context
    cobb_pkg::ctx_t                     r7_ctx_next, r7_ctx_reg;

    logic                               p_in_vld  [N];
    cobb_pkg::ctx_t                     p_in_ctx  [N];
    logic [cobb_pkg::T_W-1:0]           p_in_ta   [N];
    logic [cobb_pkg::T_W-1:0]           p_in_tb   [N];
    logic                               p_out_vld [N];
    cobb_pkg::ctx_t                     p_out_ctx [N];
    logic [cobb_pkg::SUM_W-1:0]         p_sa      [N];
    logic [cobb_pkg::SUM_W-1:0]         p_sb      [N];

    logic                               gl_vld_reg [S+1];
    cobb_pkg::ctx_t                     gl_ctx_reg [S+1];
    logic [cobb_pkg::T_W-1:0]           gl_ta_reg  [S+1];
    logic [cobb_pkg::T_W-1:0]           gl_tb_reg  [S+1];

    logic [cobb_pkg::SUM_W-1:0]         fin_best_next, fin_best_reg;
    logic [cobb_pkg::ER2_W-1:0]         fin_er2_reg;
    logic                               ovl_next, ovl_reg;
    logic [cobb_pkg::DIST_W-1:0]        dist_next, dist_reg;

    assign en        = !rsp_valid_reg || rsp_ready;
    assign req_ready = en;

    always_comb
    begin
        logic [cobb_pkg::COORD_BITS-1:0]   cc;
        logic [cobb_pkg::COORD_BITS-1:0]   bc;
        logic [cobb_pkg::QBITS-1:0]        q;
        logic signed [cobb_pkg::HX_W+1:0]  sd;
        logic signed [cobb_pkg::HX_W:0]    ed;
        for (int i = 0; i < 3; i++)
        begin
            cc = capsule_center[i*cobb_pkg::COORD_BITS +: cobb_pkg::COORD_BITS];
            bc = box_center[i*cobb_pkg::COORD_BITS +: cobb_pkg::COORD_BITS];
            q  = box_rotation[i*cobb_pkg::QBITS +: cobb_pkg::QBITS];
            r1_diff_next[i] = $signed({cc[cobb_pkg::COORD_BITS-1], cc})
                            - $signed({bc[cobb_pkg::COORD_BITS-1], bc});
            r1_u_next[i]    = -$signed({q[cobb_pkg::QBITS-1], q});
            r1_hext_next[i] = box_size[i*cobb_pkg::COORD_BITS +: cobb_pkg::COORD_BITS];
        end
        r1_w_next = $signed(box_rotation[3*cobb_pkg::QBITS +: cobb_pkg::QBITS]);
        sd = $signed({2'b00, capsule_height}) - $signed({1'b0, capsule_radius, 1'b0});
        r1_seg2_next = (sd < 0) ? '0 : sd[cobb_pkg::HX_W-1:0];
        ed = $signed({1'b0, capsule_radius}) - $signed({1'b0, skin_width});
        r1_er_next = (ed < 0) ? '0 : ed[cobb_pkg::HX_W-1:0];
    end

    always_comb
    begin
        logic [2*cobb_pkg::HX_W-1:0] ersq;
        for (int i = 0; i < 3; i++)
        begin
            r2_v_next[0][i] = cobb_pkg::V_W'(r1_diff_reg[i]) <<< 1;
            r2_v_next[1][i] = cobb_pkg::V_W'(r1_diff_reg[i]) <<< 1;
            if (i == 1)
            begin
                r2_v_next[0][i] = r2_v_next[0][i] - $signed({3'b000, r1_seg2_reg});
                r2_v_next[1][i] = r2_v_next[1][i] + $signed({3'b000, r1_seg2_reg});
            end
        end
        ersq = r1_er_reg * r1_er_reg;
        r2_er2_next = {ersq, 2'b00};
    end

    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r3_pp_next[e][i] = r2_u_reg[cobb_pkg::AX1[i]] * r2_v_reg[e][cobb_pkg::AX2[i]];
                r3_pn_next[e][i] = r2_u_reg[cobb_pkg::AX2[i]] * r2_v_reg[e][cobb_pkg::AX1[i]];
                r4_t_next[e][i]  = (cobb_pkg::C_W'(r3_pp_reg[e][i])
                                  - cobb_pkg::C_W'(r3_pn_reg[e][i])) <<< 1;
                r5_cp_next[e][i] = r4_u_reg[cobb_pkg::AX1[i]] * r4_t_reg[e][cobb_pkg::AX2[i]];
                r5_cn_next[e][i] = r4_u_reg[cobb_pkg::AX2[i]] * r4_t_reg[e][cobb_pkg::AX1[i]];
                r5_wt_next[e][i] = r4_w_reg * r4_t_reg[e][i];
            end
        end
    end

    always_comb
    begin
        logic signed [cobb_pkg::ACC_W-1:0] acc;
        logic signed [cobb_pkg::ACC_W-1:0] sh;
        for (int e = 0; e < 2; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = (cobb_pkg::ACC_W'(r5_v_reg[e][i]) <<< cobb_pkg::QSH)
                    + cobb_pkg::ACC_W'(r5_wt_reg[e][i])
                    + cobb_pkg::ACC_W'(r5_cp_reg[e][i])
                    - cobb_pkg::ACC_W'(r5_cn_reg[e][i])
                    + (cobb_pkg::ACC_W'(1) <<< (cobb_pkg::QSH - 1));
                sh = acc >>> cobb_pkg::QSH;
                r6_l_next[e][i] = sh[cobb_pkg::LS_W-1:0];
            end
        end
    end

    always_comb
    begin
        r7_ctx_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            r7_ctx_next.seg_a[i] = r6_l_reg[0][i];
            r7_ctx_next.seg_d[i] = cobb_pkg::SD_W'(r6_l_reg[1][i])
                                 - cobb_pkg::SD_W'(r6_l_reg[0][i]);
            r7_ctx_next.hext[i]  = r6_hext_reg[i];
        end
        r7_ctx_next.er2 = r6_er2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            r3_vld_reg <= 1'b0;
            r4_vld_reg <= 1'b0;
            r5_vld_reg <= 1'b0;
            r6_vld_reg <= 1'b0;
            r7_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_vld_reg <= req_valid;
            r2_vld_reg <= r1_vld_reg;
            r3_vld_reg <= r2_vld_reg;
            r4_vld_reg <= r3_vld_reg;
            r5_vld_reg <= r4_vld_reg;
            r6_vld_reg <= r5_vld_reg;
            r7_vld_reg <= r6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_diff_reg <= r1_diff_next;
            r1_u_reg    <= r1_u_next;
            r1_w_reg    <= r1_w_next;
            r1_hext_reg <= r1_hext_next;
            r1_seg2_reg <= r1_seg2_next;
            r1_er_reg   <= r1_er_next;

            r2_v_reg    <= r2_v_next;
            r2_er2_reg  <= r2_er2_next;
            r2_u_reg    <= r1_u_reg;
            r2_w_reg    <= r1_w_reg;
            r2_hext_reg <= r1_hext_reg;

            r3_pp_reg   <= r3_pp_next;
            r3_pn_reg   <= r3_pn_next;
            r3_v_reg    <= r2_v_reg;
            r3_er2_reg  <= r2_er2_reg;
            r3_u_reg    <= r2_u_reg;
            r3_w_reg    <= r2_w_reg;
            r3_hext_reg <= r2_hext_reg;

            r4_t_reg    <= r4_t_next;
            r4_v_reg    <= r3_v_reg;
            r4_er2_reg  <= r3_er2_reg;
            r4_u_reg    <= r3_u_reg;
            r4_w_reg    <= r3_w_reg;
            r4_hext_reg <= r3_hext_reg;

            r5_cp_reg   <= r5_cp_next;
            r5_cn_reg   <= r5_cn_next;
            r5_wt_reg   <= r5_wt_next;
            r5_v_reg    <= r4_v_reg;
            r5_er2_reg  <= r4_er2_reg;
            r5_hext_reg <= r4_hext_reg;

            r6_l_reg    <= r6_l_next;
            r6_er2_reg  <= r5_er2_reg;
            r6_hext_reg <= r5_hext_reg;

            r7_ctx_reg  <= r7_ctx_next;
        end
    end

    // sampler 0 covers both segment ends, samplers 1..S the search steps, S+1 the midpoint
    assign p_in_vld[0] = r7_vld_reg;
    assign p_in_ctx[0] = r7_ctx_reg;
    assign p_in_ta[0]  = '0;
    assign p_in_tb[0]  = cobb_pkg::T_W'(1) << cobb_pkg::TFRAC;

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_pair
            if (j > 0)
            begin : g_link
                assign p_in_vld[j] = gl_vld_reg[j-1];
                assign p_in_ctx[j] = gl_ctx_reg[j-1];
                assign p_in_ta[j]  = gl_ta_reg[j-1];
                assign p_in_tb[j]  = gl_tb_reg[j-1];
            end

            cobb_pair u_pair (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .in_vld  (p_in_vld[j]),
                .ctx_in  (p_in_ctx[j]),
                .ta      (p_in_ta[j]),
                .tb      (p_in_tb[j]),
                .out_vld (p_out_vld[j]),
                .ctx_out (p_out_ctx[j]),
                .sum_a   (p_sa[j]),
                .sum_b   (p_sb[j])
            );
        end

        for (j = 0; j <= S; j++)
        begin : g_glue
            localparam logic [cobb_pkg::T_W-1:0] CUR_THIRD =
                cobb_pkg::third_at((j == 0) ? 0 : j - 1);
            localparam logic [cobb_pkg::T_W-1:0] NXT_A = cobb_pkg::third_at(j);
            localparam logic [cobb_pkg::T_W-1:0] NXT_B =
                cobb_pkg::span_at(j) - cobb_pkg::third_at(j);
            localparam logic [cobb_pkg::T_W:0]   LAST_SPAN = {1'b0, cobb_pkg::span_at(S)};

            cobb_pkg::ctx_t            nctx;
            logic [cobb_pkg::T_W-1:0]  lo_new;
            logic [cobb_pkg::T_W-1:0]  ta_new;
            logic [cobb_pkg::T_W-1:0]  tb_new;
            logic [cobb_pkg::T_W:0]    mid2;
            logic                      a_less;

            always_comb
            begin
                nctx   = p_out_ctx[j];
                a_less = p_sa[j] < p_sb[j];
                if (j == 0)
                begin
                    lo_new    = '0;
                    nctx.best = a_less ? p_sa[j] : p_sb[j];
                end
                else
                begin
                    lo_new = a_less ? nctx.lo : nctx.lo + CUR_THIRD;
                end
                nctx.lo = lo_new;
                mid2    = {lo_new, 1'b0} + LAST_SPAN;
                if (j == S)
                begin
                    ta_new = mid2[cobb_pkg::T_W:1];
                    tb_new = '0;
                end
                else
                begin
                    ta_new = lo_new + NXT_A;
                    tb_new = lo_new + NXT_B;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    gl_vld_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    gl_vld_reg[j] <= p_out_vld[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    gl_ctx_reg[j] <= nctx;
                    gl_ta_reg[j]  <= ta_new;
                    gl_tb_reg[j]  <= tb_new;
                end
            end
        end
    endgenerate

    always_comb
    begin
        fin_best_next = p_out_ctx[N-1].best;
        if (p_sa[N-1] < fin_best_next)
        begin
            fin_best_next = p_sa[N-1];
        end
        if (p_sb[N-1] < fin_best_next)
        begin
            fin_best_next = p_sb[N-1];
        end
    end

    always_comb
    begin
        logic [cobb_pkg::SUM_W:0] rnd;
        logic [cobb_pkg::SUM_W:0] lhs;
        lhs = {1'b0, fin_best_reg} + {1'b0, cobb_pkg::MARGIN};
        ovl_next = lhs < (cobb_pkg::SUM_W + 1)'(fin_er2_reg);
        rnd = ({1'b0, fin_best_reg} + (cobb_pkg::SUM_W + 1)'(2)) >> 2;
        if (rnd > (cobb_pkg::SUM_W + 1)'(cobb_pkg::DIST_MAX))
        begin
            dist_next = cobb_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = rnd[cobb_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            ovl_reg       <= 1'b0;
            dist_reg      <= '0;
        end
        else if (en)
        begin
            fin_vld_reg   <= p_out_vld[N-1];
            rsp_valid_reg <= fin_vld_reg;
            ovl_reg       <= ovl_next;
            dist_reg      <= dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_best_reg <= fin_best_next;
            fin_er2_reg  <= p_out_ctx[N-1].er2;
        end
    end

    assign rsp_valid            = rsp_valid_reg;
    assign overlaps             = ovl_reg;
    assign min_squared_distance = dist_reg;

    // overlap needs best < er2 < 2^42, so the reported distance stays below 2^40
    a_ovl_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && ovl_reg) |-> (dist_reg[cobb_pkg::DIST_W-1:cobb_pkg::DIST_W-2] == 2'b00))
        else $error("overlap reported with large distance");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(r1_vld_reg) && $stable(gl_vld_reg[0]) && $stable(fin_vld_reg)))
        else $error("pipeline moved during stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && en) |=> r1_vld_reg)
        else $error("accepted beat not captured");

    a_gl_follows: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (gl_vld_reg[S] == $past(p_out_vld[S])))
        else $error("search valid lost between stages");

endmodule

`default_nettype wire
